// File: design/cfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

    // Queue between the front and the back part.
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = 2;
    localparam int QC_W    = 3;

    // Width of the stored name length.
    localparam int NLEN_W = 5;

    // Jobs handed from the front to the back part.
    localparam logic [2:0] OP_INFO      = 3'd0;
    localparam logic [2:0] OP_KEY       = 3'd1;
    localparam logic [2:0] OP_STAT_NAME = 3'd2;
    localparam logic [2:0] OP_STAT_SIGN = 3'd3;
    localparam logic [2:0] OP_PAY       = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_RESP = 2'd0;
    localparam logic [1:0] KIND_PAY  = 2'd1;
    localparam logic [1:0] KIND_KEY  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START    = 3'd0;
    localparam logic [2:0] CFG_GET_INFO = 3'd1;
    localparam logic [2:0] CFG_SET_NAME = 3'd2;
    localparam logic [2:0] CFG_GET_KEY  = 3'd3;
    localparam logic [2:0] CFG_SIGN     = 3'd4;
    localparam logic [2:0] CFG_VERSION  = 3'd5;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  code_get_info;
        logic [7:0]  code_set_name;
        logic [7:0]  code_get_key;
        logic [7:0]  code_sign;
        logic [15:0] version_word;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data;
        logic        last;
        logic [10:0] mlen;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

`default_nettype wire

// File: design/cfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  cfp_pkg::t_job   i_push_job,
    input  wire             i_pop,
    output cfp_pkg::t_job   o_head,
    output cfp_pkg::t_qstat o_stat
);
    import cfp_pkg::*;

    t_job             r_mem [Q_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QC_W'(Q_DEPTH));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("job queue read while empty");
`endif

endmodule

`default_nettype wire

// File: design/cfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_front #(
    parameter int NAME_MIN = 3,
    parameter int NAME_MAX = 16,
    parameter int SIGN_MAX = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  cfp_pkg::t_cfg            i_cfg,
    input  wire                      i_in_valid,
    input  wire  [7:0]               i_rx_byte,
    output logic                     o_in_stall,
    input  cfp_pkg::t_qstat          i_qstat,
    input  wire                      i_back_busy,
    output logic                     o_push,
    output cfp_pkg::t_job            o_push_job,
    input  wire  [cfp_pkg::NLEN_W-1:0] i_name_idx,
    output logic [cfp_pkg::NLEN_W-1:0] o_name_len,
    output logic [7:0]               o_name_byte
);
    import cfp_pkg::*;

    localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_CMD   = 2'd2;
    localparam logic [1:0] ST_DATA  = 2'd3;

    localparam logic [1:0] CMD_NAME    = 2'd0;
    localparam logic [1:0] CMD_SIGN_LO = 2'd1;
    localparam logic [1:0] CMD_PAY     = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [15:0]       r_decl, n_decl;
    logic [15:0]       r_bc, n_bc;
    logic [7:0]        r_len_hi, n_len_hi;
    logic              r_ok, n_ok;
    logic [7:0]        r_staged [NAME_MAX];
    logic [7:0]        r_stored [NAME_MAX];
    logic [7:0]        n_stored [NAME_MAX];
    logic [NLEN_W-1:0] r_name_len;

    logic        w_acc;
    logic        w_commit_pt;
    logic        w_commit;
    logic        w_byte_ok;
    logic [15:0] w_bc_inc;
    logic [15:0] w_sign_len;

    function automatic logic is_alnum(input logic [7:0] c);
        // Lower case, upper case and decimal digits.
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h30 && c <= 8'h39);
    endfunction

    assign w_bc_inc    = r_bc + 16'd1;
    assign w_sign_len  = {r_len_hi, i_rx_byte};
    assign w_byte_ok   = r_ok && is_alnum(i_rx_byte);
    assign w_commit_pt = (r_state == ST_DATA) && (r_cmd == CMD_NAME) && (w_bc_inc >= r_decl);

    // The final name byte waits until the back part has drained, so that a
    // pending info frame still reads the old name.
    assign o_in_stall = i_qstat.full
        || (w_commit_pt && !(i_qstat.empty && !i_back_busy));
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_commit   = w_acc && w_commit_pt && w_byte_ok;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_decl     = r_decl;
        n_bc       = r_bc;
        n_len_hi   = r_len_hi;
        n_ok       = r_ok;
        o_push     = 1'b0;
        o_push_job = '0;
        if (w_acc) begin
            case (r_state)
                ST_IDLE: begin
                    if (i_rx_byte == i_cfg.start_byte) begin
                        n_state = ST_START;
                    end
                end
                ST_START: begin
                    n_state = ST_IDLE;
                    if (i_rx_byte == i_cfg.code_get_info) begin
                        o_push        = 1'b1;
                        o_push_job.op = OP_INFO;
                    end else if (i_rx_byte == i_cfg.code_set_name) begin
                        n_cmd   = CMD_NAME;
                        n_state = ST_CMD;
                    end else if (i_rx_byte == i_cfg.code_get_key) begin
                        o_push        = 1'b1;
                        o_push_job.op = OP_KEY;
                    end else if (i_rx_byte == i_cfg.code_sign) begin
                        n_cmd   = CMD_SIGN_LO;
                        n_state = ST_CMD;
                    end
                end
                ST_CMD: begin
                    if (r_cmd == CMD_NAME) begin
                        if (i_rx_byte < 8'(NAME_MIN) || i_rx_byte > 8'(NAME_MAX)) begin
                            o_push          = 1'b1;
                            o_push_job.op   = OP_STAT_NAME;
                            o_push_job.data = 8'd1;
                            n_state         = ST_IDLE;
                        end else begin
                            n_decl  = {8'd0, i_rx_byte};
                            n_bc    = '0;
                            n_ok    = 1'b1;
                            n_state = ST_DATA;
                        end
                    end else begin
                        n_len_hi = i_rx_byte;
                        n_cmd    = CMD_SIGN_LO;
                        n_bc     = '0;
                        n_state  = ST_DATA;
                    end
                end
                default: begin
                    if (r_cmd == CMD_NAME) begin
                        n_ok = w_byte_ok;
                        n_bc = w_bc_inc;
                        if (w_commit_pt) begin
                            o_push          = 1'b1;
                            o_push_job.op   = OP_STAT_NAME;
                            o_push_job.data = w_byte_ok ? 8'd0 : 8'd1;
                            n_state         = ST_IDLE;
                        end
                    end else if (r_cmd == CMD_SIGN_LO) begin
                        if (w_sign_len == '0 || w_sign_len > 16'(SIGN_MAX)) begin
                            o_push          = 1'b1;
                            o_push_job.op   = OP_STAT_SIGN;
                            o_push_job.data = 8'd1;
                            n_state         = ST_IDLE;
                        end else begin
                            n_decl = w_sign_len;
                            n_bc   = '0;
                            n_cmd  = CMD_PAY;
                        end
                    end else begin
                        n_bc            = w_bc_inc;
                        o_push          = 1'b1;
                        o_push_job.op   = OP_PAY;
                        o_push_job.data = i_rx_byte;
                        o_push_job.last = (w_bc_inc >= r_decl);
                        o_push_job.mlen = r_decl[10:0];
                        if (w_bc_inc >= r_decl) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    // New name: staged bytes, the final byte in its place, zero beyond.
    always_comb begin
        for (int k = 0; k < NAME_MAX; k++) begin
            if (16'(k) < r_decl) begin
                n_stored[k] = (16'(k) == r_bc) ? i_rx_byte : r_staged[k];
            end else begin
                n_stored[k] = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && r_state == ST_DATA && r_cmd == CMD_NAME && r_bc < 16'(NAME_MAX)) begin
            r_staged[r_bc[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cmd      <= CMD_NAME;
            r_decl     <= '0;
            r_bc       <= '0;
            r_len_hi   <= '0;
            r_ok       <= 1'b1;
            r_name_len <= '0;
            for (int k = 0; k < NAME_MAX; k++) begin
                r_stored[k] <= 8'd0;
            end
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_decl   <= n_decl;
            r_bc     <= n_bc;
            r_len_hi <= n_len_hi;
            r_ok     <= n_ok;
            if (w_commit) begin
                r_name_len <= r_decl[NLEN_W-1:0];
                for (int k = 0; k < NAME_MAX; k++) begin
                    r_stored[k] <= n_stored[k];
                end
            end
        end
    end

    assign o_name_len  = r_name_len;
    assign o_name_byte = r_stored[i_name_idx[IDX_W-1:0]];

`ifndef SYNTHESIS
    a_commit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_name_len >= NLEN_W'(NAME_MIN) && r_name_len <= NLEN_W'(NAME_MAX)))
        else $error("committed name length out of range");
`endif

endmodule

`default_nettype wire

// File: design/cfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  cfp_pkg::t_cfg              i_cfg,
    input  cfp_pkg::t_qstat            i_qstat,
    input  cfp_pkg::t_job              i_head,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic [cfp_pkg::NLEN_W-1:0] o_name_idx,
    input  wire  [cfp_pkg::NLEN_W-1:0] i_name_len,
    input  wire  [7:0]                 i_name_byte,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [1:0]                 o_kind,
    output logic [7:0]                 o_value,
    output logic                       o_last,
    output logic [10:0]                o_message_length
);
    import cfp_pkg::*;

    logic              r_busy;
    t_job              r_job;
    logic [NLEN_W-1:0] r_step;
    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [7:0]        r_value;
    logic              r_last;
    logic [10:0]       r_mlen;

    logic              w_out_free;
    logic              w_emit;
    logic              w_done;
    logic [1:0]        w_kind;
    logic [7:0]        w_value;
    logic              w_last;
    logic [10:0]       w_mlen;
    logic [NLEN_W:0]   w_info_end;
    logic [7:0]        w_stat_code;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = r_busy && w_out_free;
    assign o_pop      = !r_busy && !i_qstat.empty;
    assign o_busy     = r_busy;
    // Name bytes follow the five header bytes of an info frame.
    assign o_name_idx = r_step - NLEN_W'(5);
    assign w_info_end = (NLEN_W + 1)'(4) + {1'b0, i_name_len};
    assign w_stat_code = (r_job.op == OP_STAT_SIGN) ? i_cfg.code_sign : i_cfg.code_set_name;

    always_comb begin
        w_kind  = KIND_RESP;
        w_value = 8'd0;
        w_last  = 1'b0;
        w_mlen  = '0;
        w_done  = 1'b1;
        case (r_job.op)
            OP_INFO: begin
                w_done = ({1'b0, r_step} == w_info_end);
                case (r_step)
                    NLEN_W'(0): w_value = i_cfg.start_byte;
                    NLEN_W'(1): w_value = i_cfg.code_get_info;
                    NLEN_W'(2): w_value = i_cfg.version_word[15:8];
                    NLEN_W'(3): w_value = i_cfg.version_word[7:0];
                    NLEN_W'(4): begin
                        w_value = 8'(i_name_len);
                        w_last  = (i_name_len == '0);
                    end
                    default: begin
                        w_value = i_name_byte;
                        w_last  = w_done;
                    end
                endcase
            end
            OP_STAT_NAME, OP_STAT_SIGN: begin
                w_done = (r_step == NLEN_W'(2));
                case (r_step)
                    NLEN_W'(0): w_value = i_cfg.start_byte;
                    NLEN_W'(1): w_value = w_stat_code;
                    default: begin
                        w_value = r_job.data;
                        w_last  = 1'b1;
                    end
                endcase
            end
            OP_KEY: begin
                w_kind = KIND_KEY;
            end
            OP_PAY: begin
                w_kind  = KIND_PAY;
                w_value = r_job.data;
                w_last  = r_job.last;
                w_mlen  = r_job.mlen;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (w_emit) begin
            r_kind  <= w_kind;
            r_value <= w_value;
            r_last  <= w_last;
            r_mlen  <= w_mlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_emit) begin
                r_step <= r_step + 1'b1;
                if (w_done) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_value          = r_value;
    assign o_last           = r_last;
    assign o_message_length = r_mlen;

`ifndef SYNTHESIS
    a_key_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_KEY) |-> (r_value == 8'd0 && !r_last))
        else $error("key request carries data");

    a_mlen_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_PAY) |-> (r_mlen == '0))
        else $error("message length on a non-payload beat");
`endif

endmodule

`default_nettype wire

// File: design/command_frame_parser_unit.sv
// The first result of a byte passes the job queue, the back part's job register and the output
// register. One byte a cycle goes in unless the input stalls; the back part pops no new job
// until its last is through, then sends one result a cycle unless the output stalls.
// The four-entry job queue stalls input when full; a committing name byte waits for the back part.
// Reset is synchronous and active low; the stored name resets empty, staged bytes are not reset.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser_unit #(
    parameter int NAME_MIN = 3,
    parameter int NAME_MAX = 16,
    parameter int SIGN_MAX = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_value,
    output logic        o_last,
    output logic [10:0] o_message_length,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    import cfp_pkg::*;

    t_cfg              r_cfg;
    t_job              w_push_job;
    t_job              w_head;
    t_qstat            w_qstat;
    logic              w_push;
    logic              w_pop;
    logic              w_back_busy;
    logic [NLEN_W-1:0] w_name_idx;
    logic [NLEN_W-1:0] w_name_len;
    logic [7:0]        w_name_byte;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= 8'hA5;
            r_cfg.code_get_info <= 8'd1;
            r_cfg.code_set_name <= 8'd2;
            r_cfg.code_get_key  <= 8'd3;
            r_cfg.code_sign     <= 8'd4;
            r_cfg.version_word  <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START:    r_cfg.start_byte    <= i_cfg_data[7:0];
                CFG_GET_INFO: r_cfg.code_get_info <= i_cfg_data[7:0];
                CFG_SET_NAME: r_cfg.code_set_name <= i_cfg_data[7:0];
                CFG_GET_KEY:  r_cfg.code_get_key  <= i_cfg_data[7:0];
                CFG_SIGN:     r_cfg.code_sign     <= i_cfg_data[7:0];
                CFG_VERSION:  r_cfg.version_word  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cfp_front #(
        .NAME_MIN (NAME_MIN),
        .NAME_MAX (NAME_MAX),
        .SIGN_MAX (SIGN_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .o_in_stall  (o_in_stall),
        .i_qstat     (w_qstat),
        .i_back_busy (w_back_busy),
        .o_push      (w_push),
        .o_push_job  (w_push_job),
        .i_name_idx  (w_name_idx),
        .o_name_len  (w_name_len),
        .o_name_byte (w_name_byte)
    );

    cfp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_stat     (w_qstat)
    );

    cfp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_qstat          (w_qstat),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_busy           (w_back_busy),
        .o_name_idx       (w_name_idx),
        .i_name_len       (w_name_len),
        .i_name_byte      (w_name_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_value          (o_value),
        .o_last           (o_last),
        .o_message_length (o_message_length)
    );

endmodule

`default_nettype wire

// File: dv/command_frame_parser_unit_test.sv
`timescale 1ns / 1ps

module command_frame_parser_unit_test;
    import cfp_pkg::*;

    localparam int NAME_MIN       = 3;
    localparam int NAME_MAX       = 16;
    localparam int SIGN_MAX       = 1024;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 50;
    localparam int RANDOM_PER_SET = 35;

    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LZ = "z";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_UZ = "Z";
    localparam logic [7:0] CH_D0 = "0";
    localparam logic [7:0] CH_D9 = "9";

    typedef enum logic [1:0] {PS_IDLE, PS_START, PS_CMD, PS_DATA} t_parse;
    typedef enum logic [1:0] {CMD_NAME, CMD_SIGN_LEN, CMD_SIGN_PAY} t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic        last;
        logic [10:0] mlen;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_value;
    logic        o_last;
    logic [10:0] o_message_length;
    logic        o_cfg_ready;

    // Own copy of the parser state and configuration.
    t_cfg        live_cfg;
    t_parse      ps = PS_IDLE;
    t_cmd        cmd = CMD_NAME;
    logic [15:0] decl_len = '0;
    logic [15:0] byte_cnt = '0;
    logic [7:0]  len_hi = '0;
    logic [7:0]  staged_name [NAME_MAX];
    logic        staged_ok = 1'b1;
    logic [7:0]  stored_name [NAME_MAX];
    int          stored_len = 0;

    t_beat       want_beats[$];
    int          fails = 0;
    int          reports = 0;
    bit          idle_on = 1'b1;
    int          out_hold_req = 0;
    int          hold_left = 0;
    int          stall_run = 0;
    int          quiet_cycles = 0;
    int          rx_sent = 0;

    command_frame_parser_unit #(
        .NAME_MIN(NAME_MIN),
        .NAME_MAX(NAME_MAX),
        .SIGN_MAX(SIGN_MAX)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind(o_kind),
        .o_value(o_value),
        .o_last(o_last),
        .o_message_length(o_message_length),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_cfg reset_cfg();
        t_cfg c;
        c.start_byte    = 8'hA5;
        c.code_get_info = 8'd1;
        c.code_set_name = 8'd2;
        c.code_get_key  = 8'd3;
        c.code_sign     = 8'd4;
        c.version_word  = 16'd0;
        return c;
    endfunction

    function automatic bit is_name_char(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
               (c >= CH_D0 && c <= CH_D9);
    endfunction

    function automatic logic [7:0] random_name_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26)
            return CH_LA + 8'(r);
        if (r < 52)
            return CH_UA + 8'(r - 26);
        return CH_D0 + 8'(r - 52);
    endfunction

    function automatic logic [7:0] unused_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == live_cfg.code_get_info || c == live_cfg.code_set_name ||
                   c == live_cfg.code_get_key || c == live_cfg.code_sign);
        return c;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int random_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_beat(input logic [1:0] k, input logic [7:0] v,
                                      input logic l, input logic [10:0] m);
        t_beat nb;
        nb.kind  = k;
        nb.value = v;
        nb.last  = l;
        nb.mlen  = m;
        want_beats.push_back(nb);
    endfunction

    function automatic void push_status(input logic [7:0] code, input logic [7:0] status);
        push_beat(KIND_RESP, live_cfg.start_byte, 1'b0, '0);
        push_beat(KIND_RESP, code, 1'b0, '0);
        push_beat(KIND_RESP, status, 1'b1, '0);
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] b);
        logic [15:0] full_len;
        int i;
        case (ps)
            PS_IDLE: begin
                if (b == live_cfg.start_byte)
                    ps = PS_START;
            end
            PS_START: begin
                ps = PS_IDLE;
                // Codes are tried in a fixed order, so a collision resolves to the first.
                if (b == live_cfg.code_get_info) begin
                    push_beat(KIND_RESP, live_cfg.start_byte, 1'b0, '0);
                    push_beat(KIND_RESP, live_cfg.code_get_info, 1'b0, '0);
                    push_beat(KIND_RESP, live_cfg.version_word[15:8], 1'b0, '0);
                    push_beat(KIND_RESP, live_cfg.version_word[7:0], 1'b0, '0);
                    push_beat(KIND_RESP, 8'(stored_len), stored_len == 0, '0);
                    for (i = 0; i < stored_len; i++)
                        push_beat(KIND_RESP, stored_name[i], i + 1 == stored_len, '0);
                end else if (b == live_cfg.code_set_name) begin
                    cmd = CMD_NAME;
                    ps = PS_CMD;
                end else if (b == live_cfg.code_get_key) begin
                    push_beat(KIND_KEY, 8'd0, 1'b0, '0);
                end else if (b == live_cfg.code_sign) begin
                    cmd = CMD_SIGN_LEN;
                    ps = PS_CMD;
                end
            end
            PS_CMD: begin
                if (cmd == CMD_NAME) begin
                    if (b < NAME_MIN || b > NAME_MAX) begin
                        push_status(live_cfg.code_set_name, 8'd1);
                        ps = PS_IDLE;
                    end else begin
                        decl_len = 16'(b);
                        byte_cnt = '0;
                        staged_ok = 1'b1;
                        ps = PS_DATA;
                    end
                end else begin
                    len_hi = b;
                    cmd = CMD_SIGN_LEN;
                    byte_cnt = '0;
                    ps = PS_DATA;
                end
            end
            default: begin
                if (cmd == CMD_NAME) begin
                    if (byte_cnt < NAME_MAX)
                        staged_name[byte_cnt] = b;
                    if (!is_name_char(b))
                        staged_ok = 1'b0;
                    byte_cnt = byte_cnt + 16'd1;
                    if (byte_cnt >= decl_len) begin
                        if (staged_ok) begin
                            for (i = 0; i < NAME_MAX; i++)
                                stored_name[i] = (i < decl_len) ? staged_name[i] : 8'd0;
                            stored_len = int'(decl_len);
                            push_status(live_cfg.code_set_name, 8'd0);
                        end else begin
                            push_status(live_cfg.code_set_name, 8'd1);
                        end
                        ps = PS_IDLE;
                    end
                end else if (cmd == CMD_SIGN_LEN) begin
                    full_len = {len_hi, b};
                    if (full_len == 0 || full_len > SIGN_MAX) begin
                        push_status(live_cfg.code_sign, 8'd1);
                        ps = PS_IDLE;
                    end else begin
                        decl_len = full_len;
                        byte_cnt = '0;
                        cmd = CMD_SIGN_PAY;
                    end
                end else begin
                    byte_cnt = byte_cnt + 16'd1;
                    push_beat(KIND_PAY, b, byte_cnt >= decl_len, decl_len[10:0]);
                    if (byte_cnt >= decl_len)
                        ps = PS_IDLE;
                end
            end
        endcase
    endfunction

    // Receiver: a counted hold-off when asked, else random stalls while idle_on is set.
    always @(posedge i_clk) begin
        if (out_hold_req > 0) begin
            hold_left = out_hold_req;
            out_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 35);
            stall_run = random_pause();
        end
    end

    always @(posedge i_clk) begin
        t_beat exp_beat;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (want_beats.size() == 0) begin
                fails++;
                if (reports++ < REPORT_LIMIT)
                    $display("%0t: unexpected beat kind %0d value %0h last %0b len %0d",
                             $time, o_kind, o_value, o_last, o_message_length);
            end else begin
                exp_beat = want_beats.pop_front();
                if (o_kind !== exp_beat.kind) begin
                    fails++;
                    if (reports++ < REPORT_LIMIT)
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, exp_beat.kind, o_kind);
                end
                if (o_value !== exp_beat.value) begin
                    fails++;
                    if (reports++ < REPORT_LIMIT)
                        $display("%0t: value expected %0h actual %0h",
                                 $time, exp_beat.value, o_value);
                end
                if (o_last !== exp_beat.last) begin
                    fails++;
                    if (reports++ < REPORT_LIMIT)
                        $display("%0t: last expected %0b actual %0b",
                                 $time, exp_beat.last, o_last);
                end
                if (o_message_length !== exp_beat.mlen) begin
                    fails++;
                    if (reports++ < REPORT_LIMIT)
                        $display("%0t: message_length expected %0d actual %0d",
                                 $time, exp_beat.mlen, o_message_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, want_beats.size());
            $display("[command_frame_parser_unit] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? random_pause() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_rx_byte(b);
        rx_sent++;
    endtask

    task automatic send_command(input logic [7:0] code);
        send_byte(live_cfg.start_byte);
        send_byte(code);
    endtask

    task automatic send_set_name(input logic [7:0] len, input string chars);
        int i;
        send_command(live_cfg.code_set_name);
        send_byte(len);
        for (i = 0; i < chars.len(); i++)
            send_byte(chars[i]);
    endtask

    task automatic send_sign(input int len);
        int i;
        send_command(live_cfg.code_sign);
        send_byte(8'(len >> 8));
        send_byte(8'(len));
        if (len >= 1 && len <= SIGN_MAX)
            for (i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)));
    endtask

    // Finishes whatever frame the parser is in, so that it sits idle again.
    task automatic return_parser_to_idle();
        while (ps != PS_IDLE) begin
            case (ps)
                PS_START: send_byte(unused_code());
                PS_CMD:   send_byte(8'd0);
                default: begin
                    if (cmd == CMD_NAME)
                        send_byte(CH_LA);
                    else if (cmd == CMD_SIGN_LEN)
                        send_byte(8'd0);
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (want_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input t_cfg c);
        logic [2:0]  idx [6];
        logic [15:0] vals [6];
        int i;
        idx = '{CFG_START, CFG_GET_INFO, CFG_SET_NAME, CFG_GET_KEY, CFG_SIGN, CFG_VERSION};
        vals = '{16'(c.start_byte), 16'(c.code_get_info), 16'(c.code_set_name),
                 16'(c.code_get_key), 16'(c.code_sign), c.version_word};
        for (i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        live_cfg = c;
    endtask

    task automatic reconfigure(input t_cfg c);
        return_parser_to_idle();
        settle();
        write_config(c);
    endtask

    task automatic test_reset_defaults();
        send_byte(8'hFF);
        send_command(live_cfg.code_get_info);
        send_command(live_cfg.code_get_key);
        // The start byte in the command position is an ordinary, unknown code here.
        send_command(live_cfg.start_byte);
        send_command(8'h00);
        settle();
    endtask

    task automatic test_config_registers();
        t_cfg c;
        c.start_byte = 8'h00;
        c.code_get_info = 8'hFF;
        c.code_set_name = 8'hFE;
        c.code_get_key = 8'h80;
        c.code_sign = 8'h7F;
        c.version_word = 16'hFFFF;
        reconfigure(c);
        send_command(c.code_get_info);
        send_command(c.code_get_key);
        send_command(c.start_byte);
        send_set_name(8'd4, "Cfg1");
        send_sign(2);
        // Every code the same: get info takes precedence.
        c.start_byte = 8'hFF;
        c.code_get_info = 8'h00;
        c.code_set_name = 8'h00;
        c.code_get_key = 8'h00;
        c.code_sign = 8'h00;
        c.version_word = 16'h0000;
        reconfigure(c);
        send_command(8'h00);
        // Get info coded as the start byte; the other three collide on one code.
        c.start_byte = 8'h5A;
        c.code_get_info = 8'h5A;
        c.code_set_name = 8'h20;
        c.code_get_key = 8'h20;
        c.code_sign = 8'h20;
        c.version_word = 16'h8001;
        reconfigure(c);
        send_command(8'h5A);
        send_set_name(8'd3, "Q7q");
        send_command(8'h5A);
        reconfigure(reset_cfg());
    endtask

    task automatic test_set_name();
        send_set_name(8'd2, "");
        send_set_name(8'd17, "");
        send_set_name(8'd0, "");
        send_set_name(8'd255, "");
        send_set_name(8'd3, "a9Z");
        // Neighbours of every character range, all of which are refused.
        send_set_name(8'd6, "/:@[`{");
        send_set_name(8'd4, "abc\377");
        send_command(live_cfg.code_get_info);
        send_set_name(8'd16, "azAZ09azAZ09azAZ");
        send_command(live_cfg.code_get_info);
        settle();
    endtask

    task automatic test_sign_message();
        send_sign(1);
        send_sign(0);
        send_sign(SIGN_MAX + 1);
        send_sign(65535);
        send_sign(5);
        send_sign(24);
        settle();
    endtask

    task automatic test_output_hold_off();
        int i;
        settle();
        idle_on = 1'b0;
        out_hold_req = 400;
        for (i = 0; i < 10; i++)
            send_command(live_cfg.code_get_info);
        settle();
        idle_on = 1'b1;
    endtask

    task automatic send_random_frame();
        int sel;
        int len;
        int i;
        bit spoil;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (sel < 22) begin
            send_command(live_cfg.code_get_info);
        end else if (sel < 50) begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(NAME_MIN, NAME_MAX)
                                               : $urandom_range(0, 255);
            spoil = ($urandom_range(0, 99) < 20);
            send_command(live_cfg.code_set_name);
            send_byte(8'(len));
            if (len >= NAME_MIN && len <= NAME_MAX)
                for (i = 0; i < len; i++)
                    send_byte((spoil && $urandom_range(0, 3) == 0) ?
                              8'($urandom_range(0, 255)) : random_name_char());
        end else if (sel < 60) begin
            send_command(live_cfg.code_get_key);
        end else if (sel < 88) begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                len = $urandom_range(1, 16);
            else if (sel < 85)
                len = $urandom_range(17, 64);
            else if (sel < 90)
                len = 0;
            else
                len = $urandom_range(SIGN_MAX + 1, 65535);
            send_sign(len);
        end else if (sel < 95) begin
            send_command(unused_code());
        end else begin
            // A broken frame: whatever follows the start byte.
            send_byte(live_cfg.start_byte);
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic();
        t_cfg c;
        int set_idx;
        int target;
        int base;
        for (set_idx = 0; set_idx < 4; set_idx++) begin
            case (set_idx)
                0: c = reset_cfg();
                1: begin
                    c.start_byte = 8'($urandom_range(0, 255));
                    c.code_get_info = 8'($urandom_range(0, 255));
                    c.code_set_name = 8'($urandom_range(0, 255));
                    c.code_get_key = 8'($urandom_range(0, 255));
                    c.code_sign = 8'($urandom_range(0, 255));
                    c.version_word = 16'($urandom_range(0, 65535));
                end
                2: begin
                    base = $urandom_range(0, 251);
                    c.start_byte = 8'($urandom_range(0, 255));
                    c.code_get_info = 8'(base);
                    c.code_set_name = 8'(base + 1);
                    c.code_get_key = 8'(base + 2);
                    c.code_sign = 8'(base + 3);
                    c.version_word = 16'($urandom_range(0, 65535));
                end
                default: begin
                    c.start_byte = 8'hFF;
                    c.code_get_info = 8'h00;
                    c.code_set_name = 8'h01;
                    c.code_get_key = 8'hFE;
                    c.code_sign = 8'hFF;
                    c.version_word = 16'hFFFF;
                end
            endcase
            reconfigure(c);
            target = rx_sent + RANDOM_PER_SET;
            while (rx_sent < target) begin
                if ($urandom_range(0, 15) == 0)
                    idle_on = !idle_on;
                send_random_frame();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        live_cfg = reset_cfg();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_config_registers();
        test_set_name();
        test_sign_message();
        test_output_hold_off();
        test_random_traffic();
        settle();
        if (fails == 0)
            $display("[command_frame_parser_unit] OK");
        else
            $display("[command_frame_parser_unit] ERROR");
        $finish;
    end

endmodule

// File: command_frame_parser_unit.f
design/cfp_pkg.sv
design/cfp_queue.sv
design/cfp_front.sv
design/cfp_back.sv
design/command_frame_parser_unit.sv
dv/command_frame_parser_unit_test.sv
